/* rtl/core/bzca_pkg.sv */
// shared constants and types for the border zone color averaging block
// no dependencies
package bzca_pkg;

    localparam int SPREAD_DEF   = 4;
    localparam int MAX_ZONES_DEF = 64;
    localparam int SUM_BITS_DEF = 20;

    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_ZONE_WIDTH   = 3'd2;
    localparam logic [2:0] REG_ZONE_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_START_X      = 3'd4;
    localparam logic [2:0] REG_START_Y      = 3'd5;
    localparam logic [2:0] REG_LEDS_H       = 3'd6;
    localparam logic [2:0] REG_LEDS_V       = 3'd7;

    localparam logic [1:0] SIDE_TOP    = 2'd0;
    localparam logic [1:0] SIDE_BOTTOM = 2'd1;
    localparam logic [1:0] SIDE_LEFT   = 2'd2;
    localparam logic [1:0] SIDE_RIGHT  = 2'd3;

    typedef struct packed {
        logic [11:0] frame_width;
        logic [11:0] frame_height;
        logic [7:0]  zone_width;
        logic [7:0]  zone_height;
        logic [11:0] start_x;
        logic [11:0] start_y;
        logic [6:0]  leds_horizontal;
        logic [6:0]  leds_vertical;
    } cfg_t;

    // job for the divider: side, index, three sums (max 21 bits), area, last
    // area reaches 255 * 255 * SPREAD (18 bits at the default of 4); the field has 20 bits
    typedef struct packed {
        logic [1:0]  side;
        logic [5:0]  led_index;
        logic [20:0] sum_b;
        logic [20:0] sum_g;
        logic [20:0] sum_r;
        logic [19:0] area;
        logic        last;
    } job_t;

endpackage

/* rtl/core/border_zone_color_average_top.sv */
// border zone color averaging: pixel stream in, per-zone averages out
// flow: a pixel goes through zone lookup (longer when a lookup restarts or
// steps to the next zone) and the sum update; its jobs reach the queue one
// per cycle; a result is valid once the divider has run its 21 divide steps
// on the job; the front takes a new pixel only when all jobs of the last
// pixel are pushed and three queue slots are free; lookup is longer after a
// register write moves the zone grid (walk of up to 64 steps); the divider
// takes a new job only once its last result has been taken
// reset: asynchronous active low; positions, left and right edge sums and registers reset
// depends on bzca_pkg, bzca_front, bzca_queue, bzca_div (bzca_ram via bzca_front)
module border_zone_color_average_top
    import bzca_pkg::*;
#(
    parameter int SPREAD    = SPREAD_DEF,
    parameter int MAX_ZONES = MAX_ZONES_DEF,
    parameter int SUM_BITS  = SUM_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pixel_blue, pixel_green, pixel_red
    input  logic        s_axis_tuser,   // frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // side, led_index, blue/green/red_avg
    output logic        m_axis_tlast    // last_of_run
);
    cfg_t cfg_reg;
    job_t fj, qj;
    logic fjv, pop, nonempty;
    logic [1:0] qfree;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width <= 12'd480;
            cfg_reg.frame_height <= 12'd320;
            cfg_reg.zone_width <= 8'd9;
            cfg_reg.zone_height <= 8'd11;
            cfg_reg.start_x <= 12'd6;
            cfg_reg.start_y <= 12'd6;
            cfg_reg.leds_horizontal <= 7'd52;
            cfg_reg.leds_vertical <= 7'd28;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  cfg_reg.frame_width <= cfg_data;
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data;
                REG_ZONE_WIDTH:   cfg_reg.zone_width <= cfg_data[7:0];
                REG_ZONE_HEIGHT:  cfg_reg.zone_height <= cfg_data[7:0];
                REG_START_X:      cfg_reg.start_x <= cfg_data;
                REG_START_Y:      cfg_reg.start_y <= cfg_data;
                REG_LEDS_H:       cfg_reg.leds_horizontal <= cfg_data[6:0];
                REG_LEDS_V:       cfg_reg.leds_vertical <= cfg_data[6:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    bzca_front #(.SPREAD(SPREAD), .MAX_ZONES(MAX_ZONES), .SUM_BITS(SUM_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .px_b(s_axis_tdata[7:0]), .px_g(s_axis_tdata[15:8]),
        .px_r(s_axis_tdata[23:16]), .frame_start(s_axis_tuser),
        .job_valid(fjv), .job(fj), .q_free(qfree));

    bzca_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(fjv), .din(fj), .pop(pop),
        .nonempty(nonempty), .dout(qj), .free(qfree));

    bzca_div u_div (
        .clk(clk), .rst_n(rst_n), .job_valid(nonempty), .job(qj), .job_pop(pop),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(m_axis_tdata), .out_last(m_axis_tlast));
endmodule

/* rtl/core/bzca_ram.sv */
// generic single port write, single port registered read ram
// no dependencies
module bzca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/core/bzca_front.sv */
// front end: raster tracking, zone classification, sum accumulation
// depends on bzca_pkg and bzca_ram; emits divider jobs into a queue
module bzca_front
    import bzca_pkg::*;
#(
    parameter int SPREAD    = SPREAD_DEF,
    parameter int MAX_ZONES = MAX_ZONES_DEF,
    parameter int SUM_BITS  = SUM_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  px_b,
    input  logic [7:0]  px_g,
    input  logic [7:0]  px_r,
    input  logic        frame_start,
    output logic        job_valid,
    output job_t        job,
    input  logic [1:0]  q_free
);
    localparam int IW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int SW = 3 * SUM_BITS;
    localparam logic [SUM_BITS-1:0] SMAX = {SUM_BITS{1'b1}};

    typedef enum logic [1:0] {S_IDLE, S_CLASS, S_ACC} st_t;

    // per-axis zone lookup state
    typedef struct packed {
        logic        hit;
        logic [5:0]  idx;
        logic [12:0] begin_pos;
        logic [12:0] end_pos;
    } zone_t;

    st_t st_reg;
    logic [11:0] col_reg, row_reg;
    logic [7:0] pb_reg, pg_reg, pr_reg;
    logic [11:0] cur_col_reg, cur_row_reg;
    logic [SW-1:0] left_reg, right_reg;

    // incremental zone tracking along each axis
    logic [6:0]  hk_reg, vk_reg;
    logic [12:0] hb_reg, vb_reg;
    logic        hin_reg, vin_reg;

    logic [IW-1:0] ram_addr;
    logic [SW-1:0] top_rd, bot_rd, top_wd, bot_wd;
    logic top_we, bot_we;

    logic [13:0] tall, wide;
    logic [6:0]  nh, nv;
    zone_t hz, vz;
    logic [11:0] col_c, row_c;

    assign tall = 14'(cfg.zone_height) * 14'(SPREAD);
    assign wide = 14'(cfg.zone_width) * 14'(SPREAD);
    assign nh = (cfg.leds_horizontal > 7'(MAX_ZONES)) ? 7'(MAX_ZONES) : cfg.leds_horizontal;
    assign nv = (cfg.leds_vertical > 7'(MAX_ZONES)) ? 7'(MAX_ZONES) : cfg.leds_vertical;

    assign col_c = frame_start ? 12'd0 : col_reg;
    assign row_c = frame_start ? 12'd0 : row_reg;

    function automatic logic [SUM_BITS-1:0] sat_add(logic [SUM_BITS-1:0] a,
                                                    logic [7:0] p, logic first);
        logic [SUM_BITS:0] s;
        begin
            s = first ? {{(SUM_BITS-7){1'b0}}, p} : {1'b0, a} + (SUM_BITS+1)'(p);
            sat_add = s[SUM_BITS] ? SMAX : s[SUM_BITS-1:0];
        end
    endfunction

    function automatic logic [SW-1:0] acc3(logic [SW-1:0] a, logic [7:0] b,
                                           logic [7:0] g, logic [7:0] r,
                                           logic first);
        begin
            acc3 = {sat_add(a[3*SUM_BITS-1 -: SUM_BITS], r, first),
                    sat_add(a[2*SUM_BITS-1 -: SUM_BITS], g, first),
                    sat_add(a[SUM_BITS-1:0], b, first)};
        end
    endfunction

    // zone position tracking: hk is the zone under the column, advanced as
    // the column walks; reset at line start
    always_comb
    begin
        hz.hit = hin_reg && (cfg.zone_width != 8'd0) && (hk_reg < nh)
                 && (hb_reg + 13'(cfg.zone_width) <= 13'(cfg.frame_width));
        hz.idx = hk_reg[5:0];
        hz.begin_pos = hb_reg;
        hz.end_pos = hb_reg + 13'(cfg.zone_width);
        vz.hit = vin_reg && (cfg.zone_height != 8'd0) && (vk_reg < nv)
                 && (vb_reg + 13'(cfg.zone_height) <= 13'(cfg.frame_height));
        vz.idx = vk_reg[5:0];
        vz.begin_pos = vb_reg;
        vz.end_pos = vb_reg + 13'(cfg.zone_height);
    end

    logic do_top, do_bot, do_left, do_right;
    logic em_top, em_bot, em_left, em_right;
    logic [13:0] hh;
    logic [13:0] ww;
    assign hh = 14'(cfg.frame_height);
    assign ww = 14'(cfg.frame_width);

    always_comb
    begin
        do_top = (tall <= hh) && hz.hit && (14'(cur_row_reg) < tall);
        do_bot = (tall <= hh) && hz.hit && (14'(cur_row_reg) >= hh - tall)
                 && (14'(cur_row_reg) < hh);
        do_left = (wide <= ww) && vz.hit && (14'(cur_col_reg) < wide);
        do_right = (wide <= ww) && vz.hit && (14'(cur_col_reg) >= ww - wide)
                   && (14'(cur_col_reg) < ww);
        em_top = do_top && (13'(cur_col_reg) == hz.end_pos - 13'd1)
                 && (14'(cur_row_reg) == tall - 14'd1);
        em_bot = do_bot && (13'(cur_col_reg) == hz.end_pos - 13'd1)
                 && (14'(cur_row_reg) == hh - 14'd1);
        em_left = do_left && (14'(cur_col_reg) == wide - 14'd1)
                  && (13'(cur_row_reg) == vz.end_pos - 13'd1);
        em_right = do_right && (14'(cur_col_reg) == ww - 14'd1)
                   && (13'(cur_row_reg) == vz.end_pos - 13'd1);
    end

    logic first_top, first_bot, first_left, first_right;
    assign first_top = (13'(cur_col_reg) == hz.begin_pos) && (cur_row_reg == 12'd0);
    assign first_bot = (13'(cur_col_reg) == hz.begin_pos)
                       && (14'(cur_row_reg) == hh - tall);
    assign first_left = (cur_col_reg == 12'd0) && (13'(cur_row_reg) == vz.begin_pos);
    assign first_right = (14'(cur_col_reg) == ww - wide)
                         && (13'(cur_row_reg) == vz.begin_pos);

    logic [SW-1:0] nt, nb, nl, nr;
    assign nt = acc3(top_rd, pb_reg, pg_reg, pr_reg, first_top);
    assign nb = acc3(bot_rd, pb_reg, pg_reg, pr_reg, first_bot);
    assign nl = acc3(left_reg, pb_reg, pg_reg, pr_reg, first_left);
    assign nr = acc3(right_reg, pb_reg, pg_reg, pr_reg, first_right);

    assign top_wd = nt;
    assign bot_wd = nb;
    assign top_we = (st_reg == S_ACC) && do_top;
    assign bot_we = (st_reg == S_ACC) && do_bot;
    assign ram_addr = IW'(hz.idx);

    bzca_ram #(.WIDTH(SW), .DEPTH(MAX_ZONES)) u_top (
        .clk(clk), .we(top_we), .waddr(ram_addr), .wdata(top_wd),
        .raddr(ram_addr), .rdata(top_rd));
    bzca_ram #(.WIDTH(SW), .DEPTH(MAX_ZONES)) u_bot (
        .clk(clk), .we(bot_we), .waddr(ram_addr), .wdata(bot_wd),
        .raddr(ram_addr), .rdata(bot_rd));

    // jobs are pushed one per cycle from a small list
    logic [3:0] em_reg;
    job_t jt_reg, jb_reg, jl_reg, jr_reg;

    // up to three jobs per pixel; pixel accepted only with room for three
    // and no job of the previous pixel still waiting to be pushed
    assign in_ready = (st_reg == S_IDLE) && (em_reg == 4'd0) && (q_free == 2'd3);

    logic [19:0] area_h, area_v;
    assign area_h = 20'(cfg.zone_width) * 20'(tall);
    assign area_v = 20'(wide) * 20'(cfg.zone_height);

    function automatic job_t mk(logic [1:0] s, logic [5:0] i, logic [SW-1:0] a,
                                logic [19:0] ar);
        job_t j;
        begin
            j.side = s;
            j.led_index = i;
            j.sum_b = 21'(a[SUM_BITS-1:0]);
            j.sum_g = 21'(a[2*SUM_BITS-1 -: SUM_BITS]);
            j.sum_r = 21'(a[3*SUM_BITS-1 -: SUM_BITS]);
            j.area = ar;
            j.last = 1'b0;
            mk = j;
        end
    endfunction

    logic [3:0] em_keep;
    always_comb
    begin
        em_keep = {em_right, em_left, em_bot, em_top};
        if (em_keep == 4'b1111)
        begin
            em_keep = 4'b0111;
        end
    end

    always_comb
    begin
        job_valid = 1'b0;
        job = jt_reg;
        if (em_reg[0])
        begin
            job_valid = 1'b1;
            job = jt_reg;
            job.last = (em_reg[3:1] == 3'd0);
        end
        else if (em_reg[1])
        begin
            job_valid = 1'b1;
            job = jb_reg;
            job.last = (em_reg[3:2] == 2'd0);
        end
        else if (em_reg[2])
        begin
            job_valid = 1'b1;
            job = jl_reg;
            job.last = !em_reg[3];
        end
        else if (em_reg[3])
        begin
            job_valid = 1'b1;
            job = jr_reg;
            job.last = 1'b1;
        end
    end

    logic [3:0] em_clr;
    always_comb
    begin
        em_clr = em_reg;
        if (em_reg[0]) em_clr[0] = 1'b0;
        else if (em_reg[1]) em_clr[1] = 1'b0;
        else if (em_reg[2]) em_clr[2] = 1'b0;
        else em_clr[3] = 1'b0;
    end

    // next tracking values for the following pixel
    logic [11:0] ncol, nrow;
    logic wrap_c;
    always_comb
    begin
        wrap_c = (13'(cur_col_reg) + 13'd1) >= 13'(cfg.frame_width);
        ncol = wrap_c ? 12'd0 : cur_col_reg + 12'd1;
        nrow = cur_row_reg;
        if (wrap_c)
        begin
            nrow = ((13'(cur_row_reg) + 13'd1) >= 13'(cfg.frame_height))
                   ? 12'd0 : cur_row_reg + 12'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            col_reg <= '0;
            row_reg <= '0;
            left_reg <= '0;
            right_reg <= '0;
            em_reg <= '0;
            hk_reg <= '0;
            vk_reg <= '0;
            hb_reg <= '0;
            vb_reg <= '0;
            hin_reg <= 1'b0;
            vin_reg <= 1'b0;
        end
        else
        begin
            if (em_reg != 4'd0)
            begin
                em_reg <= em_clr;
            end
            case (st_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready && em_reg == 4'd0)
                    begin
                        pb_reg <= px_b;
                        pg_reg <= px_g;
                        pr_reg <= px_r;
                        cur_col_reg <= col_c;
                        cur_row_reg <= row_c;
                        st_reg <= S_CLASS;
                    end
                end
                S_CLASS:
                begin
                    // locate zone along both axes by a short walk from the
                    // zone origin; one step per cycle
                    if (13'(cur_col_reg) < 13'(cfg.start_x) || cfg.zone_width == 8'd0)
                    begin
                        hin_reg <= 1'b0;
                        hk_reg <= '0;
                        hb_reg <= 13'(cfg.start_x);
                    end
                    else if (!hin_reg || hb_reg > 13'(cur_col_reg))
                    begin
                        hin_reg <= 1'b1;
                        hk_reg <= '0;
                        hb_reg <= 13'(cfg.start_x);
                    end
                    else if (13'(cur_col_reg) >= hb_reg + 13'(cfg.zone_width)
                             && hk_reg < 7'd64)
                    begin
                        hk_reg <= hk_reg + 7'd1;
                        hb_reg <= hb_reg + 13'(cfg.zone_width);
                    end
                    if (13'(cur_row_reg) < 13'(cfg.start_y) || cfg.zone_height == 8'd0)
                    begin
                        vin_reg <= 1'b0;
                        vk_reg <= '0;
                        vb_reg <= 13'(cfg.start_y);
                    end
                    else if (!vin_reg || vb_reg > 13'(cur_row_reg))
                    begin
                        vin_reg <= 1'b1;
                        vk_reg <= '0;
                        vb_reg <= 13'(cfg.start_y);
                    end
                    else if (13'(cur_row_reg) >= vb_reg + 13'(cfg.zone_height)
                             && vk_reg < 7'd64)
                    begin
                        vk_reg <= vk_reg + 7'd1;
                        vb_reg <= vb_reg + 13'(cfg.zone_height);
                    end
                    // settled when both lookups are stable; ram read follows
                    if ((!(13'(cur_col_reg) >= 13'(cfg.start_x) && cfg.zone_width != 8'd0)
                         || (hin_reg && hb_reg <= 13'(cur_col_reg)
                             && (13'(cur_col_reg) < hb_reg + 13'(cfg.zone_width)
                                 || hk_reg >= 7'd64)))
                        && (!(13'(cur_row_reg) >= 13'(cfg.start_y)
                              && cfg.zone_height != 8'd0)
                            || (vin_reg && vb_reg <= 13'(cur_row_reg)
                                && (13'(cur_row_reg) < vb_reg + 13'(cfg.zone_height)
                                    || vk_reg >= 7'd64))))
                    begin
                        st_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    if (do_left) left_reg <= nl;
                    if (do_right) right_reg <= nr;
                    jt_reg <= mk(SIDE_TOP, hz.idx, nt, area_h);
                    jb_reg <= mk(SIDE_BOTTOM, hz.idx, nb, area_h);
                    jl_reg <= mk(SIDE_LEFT, vz.idx, nl, area_v);
                    jr_reg <= mk(SIDE_RIGHT, vz.idx, nr, area_v);
                    em_reg <= em_keep;
                    col_reg <= ncol;
                    row_reg <= nrow;
                    st_reg <= S_IDLE;
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

/* rtl/core/bzca_queue.sv */
// short job queue between classifier front and divider back end
// depends on bzca_pkg
module bzca_queue
    import bzca_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  job_t       din,
    input  logic       pop,
    output logic       nonempty,
    output job_t       dout,
    output logic [1:0] free
);
    job_t q [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign nonempty = cnt_reg != 3'd0;
    assign dout = q[rp_reg];
    // free slots, capped at three
    assign free = (cnt_reg <= 3'd1) ? 2'd3 : 2'(3'd4 - cnt_reg);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q[wp_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end
endmodule

/* rtl/core/bzca_div.sv */
// back end: restoring divider for three channel sums, one bit per cycle
// depends on bzca_pkg; output register toward the result stream
module bzca_div
    import bzca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  job_t        job,
    output logic        job_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_data,
    output logic        out_last
);
    typedef enum logic [1:0] {D_IDLE, D_RUN, D_OUT} st_t;

    st_t st_reg;
    job_t j_reg;
    logic [4:0] n_reg;
    logic [20:0] qb_reg, qg_reg, qr_reg;
    logic [19:0] rb_reg, rg_reg, rr_reg;

    function automatic logic [20:0] step(logic [19:0] r, logic b, logic [19:0] d);
        logic [20:0] t;
        logic [21:0] s;
        begin
            t = {r, b};
            s = {1'b0, t} - {2'b0, d};
            step = s[21] ? t : s[20:0];
        end
    endfunction

    logic [20:0] sb, sg, sr;
    assign sb = step(rb_reg, qb_reg[20], j_reg.area);
    assign sg = step(rg_reg, qg_reg[20], j_reg.area);
    assign sr = step(rr_reg, qr_reg[20], j_reg.area);

    function automatic logic [7:0] clamp(logic [20:0] q);
        begin
            clamp = (q > 21'd255) ? 8'd255 : q[7:0];
        end
    endfunction

    assign job_pop = (st_reg == D_IDLE) && job_valid;
    assign out_valid = (st_reg == D_OUT);
    assign out_data = {clamp(qr_reg), clamp(qg_reg), clamp(qb_reg),
                       j_reg.led_index, j_reg.side};
    assign out_last = j_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= D_IDLE;
            n_reg <= '0;
        end
        else
        begin
            case (st_reg)
                D_IDLE:
                begin
                    if (job_valid)
                    begin
                        j_reg <= job;
                        qb_reg <= job.sum_b;
                        qg_reg <= job.sum_g;
                        qr_reg <= job.sum_r;
                        rb_reg <= '0;
                        rg_reg <= '0;
                        rr_reg <= '0;
                        n_reg <= 5'd0;
                        st_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    // quotient bits shift in where dividend bits leave
                    rb_reg <= sb[19:0];
                    rg_reg <= sg[19:0];
                    rr_reg <= sr[19:0];
                    qb_reg <= {qb_reg[19:0], (sb != {rb_reg, qb_reg[20]})};
                    qg_reg <= {qg_reg[19:0], (sg != {rg_reg, qg_reg[20]})};
                    qr_reg <= {qr_reg[19:0], (sr != {rr_reg, qr_reg[20]})};
                    n_reg <= n_reg + 5'd1;
                    if (n_reg == 5'd20)
                    begin
                        st_reg <= D_OUT;
                    end
                end
                D_OUT:
                begin
                    if (out_ready)
                    begin
                        st_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= D_IDLE;
                end
            endcase
        end
    end
endmodule
